>>> hdl/assert_macros.svh
// Shared assertion macros; expect clk and arst_n in the using scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge outside reset.
`define SFB_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// Check that a condition never holds outside reset.
`define SFB_ASSERT_NEVER(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) \
		else $error(msg);

`endif

>>> hdl/sfb_pkg.sv
package sfb_pkg;

	localparam int MAX_PAYLOAD = 128;
	localparam logic [7:0] MAX_LEN = 8'(MAX_PAYLOAD);

	localparam int QDEPTH = 4;
	localparam int QAW = $clog2(QDEPTH);

	localparam logic [7:0] CRC8_INIT = 8'hFF;
	localparam logic [7:0] CRC8_POLY = 8'h8C;
	localparam logic [15:0] CRC16_INIT = 16'hFFFF;
	localparam logic [15:0] CRC16_POLY = 16'h8408;

	localparam logic CFG_START = 1'b0;
	localparam logic CFG_CMD = 1'b1;

	typedef struct packed {
		logic [7:0] data;
		logic [7:0] len;
		logic first;
		logic last;
	} sfb_entry_t;

	function automatic logic [7:0] crc8_upd(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] c;
		c = crc ^ b;
		for (int i = 0; i < 8; i++) begin
			c = c[0] ? ((c >> 1) ^ CRC8_POLY) : (c >> 1);
		end
		return c;
	endfunction

	function automatic logic [15:0] crc16_upd(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int i = 0; i < 8; i++) begin
			c = c[0] ? ((c >> 1) ^ CRC16_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage

>>> hdl/serial_frame_builder_crc8_crc16_top.sv
// Serial frame builder: turns a stream of payload bytes into framed bytes.
// Input channel (in_valid/in_ready): one payload byte per item; payload_length
// is sampled on the first item of a frame, 0 counts as 1 and values above 128
// saturate to 128. Output channel (out_valid/out_ready): one frame byte per
// item, frame_end high on the last CRC-16 byte.
// Each frame: start byte, length (2 bytes), sequence, CRC-8, command id
// (2 bytes), payload, CRC-16 (2 bytes, low first).
// Config port: cfg_we writes cfg_data into register cfg_index (0 start byte,
// 1 command id); write only while idle, it applies from the next header.
// An accepted item passes through the queue to the output byte register.
// One byte per cycle on the output while out_ready is high; mid-frame items
// pass at one per cycle, a first item yields 8 output bytes, a last item 3,
// both limited by the single output byte register. A 4-entry queue between
// the input classifier and the byte sequencer absorbs these bursts.
// Reset: queue empty, sequence 0, start byte 0xA5, command id 0x0301.
// When out_ready is low the output byte holds, the sequencer stalls and
// in_ready drops once the queue fills.
module serial_frame_builder_crc8_crc16_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  payload_byte,
	input  logic [7:0]  payload_length,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  tx_byte,
	output logic        frame_end,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data
);
	import sfb_pkg::*;

	logic [7:0]  start_byte_q;
	logic [15:0] command_id_q;
	logic        push;
	logic        full;
	logic        pop;
	logic        head_valid;
	sfb_entry_t  entry;
	sfb_entry_t  head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_byte_q <= 8'hA5;
			command_id_q <= 16'h0301;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_START: start_byte_q <= cfg_data[7:0];
				CFG_CMD: command_id_q <= cfg_data;
				default: ;
			endcase
		end
	end

	sfb_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.payload_byte   (payload_byte),
		.payload_length (payload_length),
		.full           (full),
		.push           (push),
		.entry          (entry)
	);

	sfb_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (entry),
		.full   (full),
		.pop    (pop),
		.rdata  (head),
		.rvalid (head_valid)
	);

	sfb_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.head_valid (head_valid),
		.pop        (pop),
		.start_byte (start_byte_q),
		.command_id (command_id_q),
		.tx_byte    (tx_byte),
		.frame_end  (frame_end),
		.out_valid  (out_valid),
		.out_ready  (out_ready)
	);

endmodule

>>> hdl/sfb_front.sv
module sfb_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [7:0]         payload_byte,
	input  logic [7:0]         payload_length,
	input  logic               full,
	output logic               push,
	output sfb_pkg::sfb_entry_t entry
);
	import sfb_pkg::*;

	logic       in_frame_q;
	logic [7:0] left_q;
	logic [7:0] len_eff;
	logic [7:0] left;
	logic [7:0] left_next;

	always_comb begin
		if (payload_length == 8'd0) begin
			len_eff = 8'd1;
		end else if (payload_length > MAX_LEN) begin
			len_eff = MAX_LEN;
		end else begin
			len_eff = payload_length;
		end
		left = in_frame_q ? left_q : len_eff;
		left_next = left - 8'd1;
		in_ready = !full;
		push = in_valid && !full;
		entry.data = payload_byte;
		entry.len = len_eff;
		entry.first = !in_frame_q;
		entry.last = (left_next == 8'd0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q <= 1'b0;
			left_q <= 8'd0;
		end else if (push) begin
			in_frame_q <= (left_next != 8'd0);
			left_q <= left_next;
		end
	end

endmodule

>>> hdl/sfb_fifo.sv
module sfb_fifo (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  sfb_pkg::sfb_entry_t wdata,
	output logic               full,
	input  logic               pop,
	output sfb_pkg::sfb_entry_t rdata,
	output logic               rvalid
);
	import sfb_pkg::*;

	`include "assert_macros.svh"

	sfb_entry_t     mem_q [QDEPTH];
	logic [QAW-1:0] wp_q;
	logic [QAW-1:0] rp_q;
	logic [QAW:0]   cnt_q;

	assign full = (cnt_q == (QAW+1)'(QDEPTH));
	assign rvalid = (cnt_q != '0);
	assign rdata = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= wp_q + 1'b1;
			end
			if (pop) begin
				rp_q <= rp_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	`SFB_ASSERT_NEVER(a_cnt_max, cnt_q > (QAW+1)'(QDEPTH), "queue count above depth")
	`SFB_ASSERT_NEVER(a_pop_empty, pop && (cnt_q == '0), "pop from empty queue")
	`SFB_ASSERT(a_cnt_up, push && !pop |=> cnt_q == $past(cnt_q) + 1'b1, "count missed push")

endmodule

>>> hdl/sfb_back.sv
module sfb_back (
	input  logic               clk,
	input  logic               arst_n,
	input  sfb_pkg::sfb_entry_t head,
	input  logic               head_valid,
	output logic               pop,
	input  logic [7:0]         start_byte,
	input  logic [15:0]        command_id,
	output logic [7:0]         tx_byte,
	output logic               frame_end,
	output logic               out_valid,
	input  logic               out_ready
);
	import sfb_pkg::*;

	`include "assert_macros.svh"

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_HDR1,
		ST_HDR2,
		ST_HDR3,
		ST_HDR4,
		ST_HDR5,
		ST_HDR6,
		ST_DATA,
		ST_CRCLO,
		ST_CRCHI
	} step_t;

	step_t       step_q;
	step_t       step_d;
	logic [7:0]  seq_q;
	logic [7:0]  hc_q;
	logic [15:0] crc_q;
	logic [15:0] crc_base;
	logic [7:0]  byte_d;
	logic        end_d;
	logic        covered;
	logic        can_load;
	logic        emit;
	logic        need_head;
	logic [7:0]  tx_byte_q;
	logic        frame_end_q;
	logic        out_valid_q;

	always_comb begin
		can_load = !out_valid_q || out_ready;
		byte_d = head.data;
		end_d = 1'b0;
		covered = 1'b1;
		step_d = step_q;
		emit = can_load;
		pop = 1'b0;
		case (step_q)
			ST_IDLE: begin
				emit = head_valid && can_load;
				if (head.first) begin
					byte_d = start_byte;
					step_d = ST_HDR1;
				end else begin
					pop = emit;
					step_d = head.last ? ST_CRCLO : ST_IDLE;
				end
			end
			ST_HDR1: begin
				byte_d = head.len;
				step_d = ST_HDR2;
			end
			ST_HDR2: begin
				byte_d = 8'h00;
				step_d = ST_HDR3;
			end
			ST_HDR3: begin
				byte_d = seq_q;
				step_d = ST_HDR4;
			end
			ST_HDR4: begin
				byte_d = hc_q;
				step_d = ST_HDR5;
			end
			ST_HDR5: begin
				byte_d = command_id[7:0];
				step_d = ST_HDR6;
			end
			ST_HDR6: begin
				byte_d = command_id[15:8];
				step_d = ST_DATA;
			end
			ST_DATA: begin
				pop = can_load;
				step_d = head.last ? ST_CRCLO : ST_IDLE;
			end
			ST_CRCLO: begin
				byte_d = crc_q[7:0];
				covered = 1'b0;
				step_d = ST_CRCHI;
			end
			ST_CRCHI: begin
				byte_d = crc_q[15:8];
				end_d = 1'b1;
				covered = 1'b0;
				step_d = ST_IDLE;
			end
			default: begin
				emit = 1'b0;
				step_d = ST_IDLE;
			end
		endcase
		crc_base = (step_q == ST_IDLE && head.first) ? CRC16_INIT : crc_q;
		need_head = (step_q != ST_IDLE) && (step_q != ST_CRCLO) && (step_q != ST_CRCHI);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= ST_IDLE;
			seq_q <= 8'd0;
			hc_q <= CRC8_INIT;
			crc_q <= CRC16_INIT;
			tx_byte_q <= 8'd0;
			frame_end_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (emit) begin
				step_q <= step_d;
				tx_byte_q <= byte_d;
				frame_end_q <= end_d;
				if (covered) begin
					crc_q <= crc16_upd(crc_base, byte_d);
				end
				if (step_q == ST_IDLE) begin
					hc_q <= crc8_upd(CRC8_INIT, start_byte);
				end else if (step_q inside {ST_HDR1, ST_HDR2, ST_HDR3}) begin
					hc_q <= crc8_upd(hc_q, byte_d);
				end
				if (step_q == ST_CRCHI) begin
					seq_q <= seq_q + 8'd1;
					crc_q <= CRC16_INIT;
				end
			end
		end
	end

	assign tx_byte = tx_byte_q;
	assign frame_end = frame_end_q;
	assign out_valid = out_valid_q;

	`SFB_ASSERT(a_hdr_head, need_head |-> head_valid, "frame step without queued item")
	`SFB_ASSERT(a_seq_adv, emit && (step_q == ST_CRCHI) |=> seq_q == $past(seq_q) + 8'd1, "no seq step")
	`SFB_ASSERT(a_end_idle, out_valid_q && frame_end_q |-> step_q == ST_IDLE, "frame end outside idle")

endmodule

>>> tb/sv/tb_serial_frame_builder_crc8_crc16_top.sv
module tb_serial_frame_builder_crc8_crc16_top;
	timeunit 1ns;
	timeprecision 1ps;

	import sfb_pkg::*;

	localparam int LIMIT_CYCLES = 200000;
	localparam int RANDOM_ITEMS = 340;
	localparam int SETTLE_CYCLES = 8;
	localparam logic [7:0] HDR_CRC_INIT = 8'hFF;
	localparam logic [7:0] HDR_CRC_POLY = 8'h8C;
	localparam logic [15:0] BODY_CRC_INIT = 16'hFFFF;
	localparam logic [15:0] BODY_CRC_POLY = 16'h8408;

	typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;
	typedef enum logic [1:0] {RX_FLOW, RX_COIN, RX_SPARSE, RX_BLOCKED} rx_mode_t;

	typedef struct packed {
		row_kind_t kind;
		logic [7:0] data;
		logic [7:0] len;
		logic idx;
		logic [15:0] val;
		logic typed;
		logic [7:0] t_start;
		logic [7:0] t_len;
	} dir_row_t;

	typedef struct packed {
		logic [7:0] tx;
		logic last;
	} tx_beat_t;

	localparam dir_row_t DIRECTED [18] = '{
		'{ROW_ITEM, 8'h00, 8'd1, CFG_START, 16'h0000, 1'b1, 8'hA5, 8'd1},
		'{ROW_ITEM, 8'hFF, 8'd0, CFG_START, 16'h0000, 1'b1, 8'hA5, 8'd1},
		'{ROW_CFG, 8'h00, 8'd0, CFG_START, 16'h0000, 1'b0, 8'h00, 8'd0},
		'{ROW_CFG, 8'h00, 8'd0, CFG_CMD, 16'h0000, 1'b0, 8'h00, 8'd0},
		'{ROW_ITEM, 8'h80, 8'd2, CFG_START, 16'h0000, 1'b1, 8'h00, 8'd2},
		'{ROW_ITEM, 8'h7F, 8'hFF, CFG_START, 16'h0000, 1'b0, 8'h00, 8'd0},
		'{ROW_CFG, 8'h00, 8'd0, CFG_START, 16'hFFFF, 1'b0, 8'h00, 8'd0},
		'{ROW_CFG, 8'h00, 8'd0, CFG_CMD, 16'hFFFF, 1'b0, 8'h00, 8'd0},
		'{ROW_ITEM, 8'h01, 8'd3, CFG_START, 16'h0000, 1'b1, 8'hFF, 8'd3},
		'{ROW_CFG, 8'h00, 8'd0, CFG_START, 16'h003C, 1'b0, 8'h00, 8'd0},
		'{ROW_CFG, 8'h00, 8'd0, CFG_CMD, 16'h1234, 1'b0, 8'h00, 8'd0},
		'{ROW_ITEM, 8'hAA, 8'd1, CFG_START, 16'h0000, 1'b0, 8'h00, 8'd0},
		'{ROW_ITEM, 8'h55, 8'd0, CFG_START, 16'h0000, 1'b0, 8'h00, 8'd0},
		'{ROW_ITEM, 8'hC3, 8'd4, CFG_START, 16'h0000, 1'b1, 8'h3C, 8'd4},
		'{ROW_ITEM, 8'h3C, 8'h80, CFG_START, 16'h0000, 1'b0, 8'h00, 8'd0},
		'{ROW_ITEM, 8'h0F, 8'h00, CFG_START, 16'h0000, 1'b0, 8'h00, 8'd0},
		'{ROW_ITEM, 8'hF0, 8'h07, CFG_START, 16'h0000, 1'b0, 8'h00, 8'd0},
		'{ROW_ITEM, 8'h99, 8'hFF, CFG_START, 16'h0000, 1'b1, 8'h3C, 8'h80}
	};

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic [7:0] payload_byte;
	logic [7:0] payload_length;
	logic out_valid;
	logic out_ready;
	logic [7:0] tx_byte;
	logic frame_end;
	logic cfg_we;
	logic cfg_index;
	logic [15:0] cfg_data;

	logic [7:0] start_reg;
	logic [15:0] cmd_reg;
	logic [7:0] seq_num;
	logic [15:0] body_crc;
	logic [7:0] bytes_remaining;
	bit in_frame_p;

	tx_beat_t expected_tx_q[$];
	tx_beat_t want;
	int errors;
	int burst_left;
	bit row_typed;
	logic [7:0] row_start;
	logic [7:0] row_len;
	rx_mode_t rx_mode;
	int rx_left;

	serial_frame_builder_crc8_crc16_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.payload_byte(payload_byte),
		.payload_length(payload_length),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.tx_byte(tx_byte),
		.frame_end(frame_end),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic [7:0] hdr_crc_next(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] r;
		r = crc ^ b;
		repeat (8) r = r[0] ? ({1'b0, r[7:1]} ^ HDR_CRC_POLY) : {1'b0, r[7:1]};
		return r;
	endfunction

	function automatic logic [15:0] body_crc_next(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] r;
		r = crc ^ {8'h00, b};
		repeat (8) r = r[0] ? ({1'b0, r[15:1]} ^ BODY_CRC_POLY) : {1'b0, r[15:1]};
		return r;
	endfunction

	task automatic push_covered(input logic [7:0] b, input logic [7:0] shown);
		body_crc = body_crc_next(body_crc, b);
		expected_tx_q.push_back('{tx: shown, last: 1'b0});
	endtask

	task automatic frame_predict(input logic [7:0] data, input logic [7:0] len, input bit typed,
			input logic [7:0] t_start, input logic [7:0] t_len);
		logic [15:0] eff;
		logic [7:0] hc;
		logic [15:0] c;
		if (!in_frame_p) begin
			if (len > MAX_PAYLOAD)
				eff = 16'(MAX_PAYLOAD);
			else if (len == 8'd0)
				eff = 16'd1;
			else
				eff = {8'h00, len};
			hc = hdr_crc_next(HDR_CRC_INIT, start_reg);
			hc = hdr_crc_next(hc, eff[7:0]);
			hc = hdr_crc_next(hc, eff[15:8]);
			hc = hdr_crc_next(hc, seq_num);
			body_crc = BODY_CRC_INIT;
			push_covered(start_reg, typed ? t_start : start_reg);
			push_covered(eff[7:0], typed ? t_len : eff[7:0]);
			push_covered(eff[15:8], eff[15:8]);
			push_covered(seq_num, seq_num);
			push_covered(hc, hc);
			push_covered(cmd_reg[7:0], cmd_reg[7:0]);
			push_covered(cmd_reg[15:8], cmd_reg[15:8]);
			bytes_remaining = eff[7:0];
			in_frame_p = 1'b1;
		end
		push_covered(data, data);
		bytes_remaining = bytes_remaining - 8'd1;
		if (bytes_remaining == 8'd0) begin
			c = body_crc;
			expected_tx_q.push_back('{tx: c[7:0], last: 1'b0});
			expected_tx_q.push_back('{tx: c[15:8], last: 1'b1});
			seq_num = seq_num + 8'd1;
			body_crc = BODY_CRC_INIT;
			in_frame_p = 1'b0;
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (expected_tx_q.size() == 0) begin
				errors++;
				$display("%0t unexpected item: tx_byte %02h frame_end %0b", $time, tx_byte,
					frame_end);
			end else begin
				want = expected_tx_q.pop_front();
				if (tx_byte !== want.tx) begin
					errors++;
					$display("%0t tx_byte expected %02h actual %02h", $time, want.tx, tx_byte);
				end
				if (frame_end !== want.last) begin
					errors++;
					$display("%0t frame_end expected %0b actual %0b", $time, want.last,
						frame_end);
				end
			end
		end
		if (arst_n && in_valid && in_ready)
			frame_predict(payload_byte, payload_length, row_typed, row_start, row_len);
	end

	initial begin
		out_ready = 1'b0;
		rx_left = 0;
		rx_mode = RX_FLOW;
		forever begin
			@(negedge clk);
			if (rx_left == 0) begin
				rx_mode = rx_mode_t'($urandom_range(0, 3));
				rx_left = (rx_mode == RX_BLOCKED) ? $urandom_range(2, 12) : $urandom_range(16, 80);
			end
			rx_left--;
			case (rx_mode)
				RX_FLOW: out_ready = 1'b1;
				RX_COIN: out_ready = 1'($urandom_range(0, 1));
				RX_SPARSE: out_ready = ($urandom_range(0, 3) == 0);
				default: out_ready = 1'b0;
			endcase
		end
	end

	initial begin
		repeat (LIMIT_CYCLES) @(posedge clk);
		$display("FAIL serial_frame_builder_crc8_crc16_top");
		$finish;
	end

	task automatic offer_item(input logic [7:0] d, input logic [7:0] l, input bit typed,
			input logic [7:0] ts, input logic [7:0] tl);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 6);
			if (gap != 0) begin
				in_valid = 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 100) : $urandom_range(1, 12);
		end
		burst_left--;
		in_valid = 1'b1;
		payload_byte = d;
		payload_length = l;
		row_typed = typed;
		row_start = ts;
		row_len = tl;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
	endtask

	task automatic settle();
		in_valid = 1'b0;
		while (expected_tx_q.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [15:0] val);
		settle();
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		if (idx == CFG_START)
			start_reg = val[7:0];
		else
			cmd_reg = val;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	initial begin
		int sent;
		int pick;
		logic [7:0] len;
		logic [15:0] val;
		arst_n = 1'b0;
		in_valid = 1'b0;
		payload_byte = 8'h00;
		payload_length = 8'h00;
		cfg_we = 1'b0;
		cfg_index = CFG_START;
		cfg_data = 16'h0000;
		row_typed = 1'b0;
		row_start = 8'h00;
		row_len = 8'h00;
		errors = 0;
		burst_left = 0;
		start_reg = 8'hA5;
		cmd_reg = 16'h0301;
		seq_num = 8'h00;
		body_crc = BODY_CRC_INIT;
		bytes_remaining = 8'h00;
		in_frame_p = 1'b0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (DIRECTED[i]) begin
			if (DIRECTED[i].kind == ROW_CFG)
				write_reg(DIRECTED[i].idx, DIRECTED[i].val);
			else
				offer_item(DIRECTED[i].data, DIRECTED[i].len, DIRECTED[i].typed,
					DIRECTED[i].t_start, DIRECTED[i].t_len);
		end

		sent = 0;
		while (sent < RANDOM_ITEMS || in_frame_p) begin
			if ($urandom_range(0, 15) == 0) begin
				case ($urandom_range(0, 3))
					0: val = 16'h0000;
					1: val = 16'hFFFF;
					default: val = 16'($urandom);
				endcase
				write_reg($urandom_range(0, 1) ? CFG_CMD : CFG_START, val);
			end
			if (!in_frame_p) begin
				pick = $urandom_range(0, 99);
				if (pick < 3)
					len = 8'($urandom_range(64, 255));
				else if (pick < 10)
					len = 8'h00;
				else
					len = 8'($urandom_range(1, 12));
			end else begin
				len = 8'($urandom_range(0, 255));
			end
			offer_item(8'($urandom_range(0, 255)), len, 1'b0, 8'h00, 8'h00);
			sent++;
		end

		settle();
		if (errors == 0)
			$display("PASS serial_frame_builder_crc8_crc16_top");
		else
			$display("FAIL serial_frame_builder_crc8_crc16_top");
		$finish;
	end

endmodule

>>> sim.f
+incdir+hdl
hdl/sfb_pkg.sv
hdl/sfb_front.sv
hdl/sfb_fifo.sv
hdl/sfb_back.sv
hdl/serial_frame_builder_crc8_crc16_top.sv
tb/sv/tb_serial_frame_builder_crc8_crc16_top.sv
